/* hw/rtl/x86ex_pkg.sv */
// Shared types, codes and constants for the x86 subset executor.
// No dependencies; imported by the front end, the back end and the top level.
package x86ex_pkg;

    localparam int unsigned MEM_BYTES_DEF = 65536;
    localparam int unsigned NUM_REGS_DEF  = 8;
    localparam int unsigned QDEPTH        = 2;

    // opcode patterns
    localparam logic [5:0] OPC_MOV_RM  = 6'b100010;
    localparam logic [3:0] OPC_MOV_IMR = 4'b1011;
    localparam logic [6:0] OPC_MOV_IRM = 7'b1100011;
    localparam logic [5:0] OPC_GRP_IMM = 6'b100000;
    localparam logic [3:0] OPC_JCC     = 4'b0111;
    localparam logic [3:0] OPC_LOOP    = 4'b1110;

    // arithmetic slot codes
    localparam logic [2:0] ALU_ADD = 3'd0;
    localparam logic [2:0] ALU_SUB = 3'd5;
    localparam logic [2:0] ALU_CMP = 3'd7;

    // jump condition codes
    localparam logic [3:0] CC_E  = 4'd4;
    localparam logic [3:0] CC_NE = 4'd5;
    localparam logic [3:0] LOOP_NZ = 4'd0;

    // configuration register indexes
    localparam logic [1:0] CFG_EXEC   = 2'd0;
    localparam logic [1:0] CFG_CLOCKS = 2'd1;
    localparam logic [1:0] CFG_END    = 2'd2;

    typedef enum logic [2:0] {K_NONE, K_MOV, K_ADD, K_SUB, K_CMP} kind_t;
    typedef enum logic [1:0] {SRC_REG, SRC_MEM, SRC_IMM} src_t;
    typedef enum logic [1:0] {J_NONE, J_JE, J_JNZ, J_LOOPNZ} jump_t;
    typedef enum logic [1:0] {S_CLEAR, S_ADDR, S_EXEC} state_t;

    typedef struct packed {
        logic        err;
        logic [2:0]  len;
        logic        w;
        kind_t       kind;
        logic        dst_mem;
        src_t        src;
        logic [2:0]  dreg;
        logic [2:0]  sreg;
        logic [15:0] imm;
        logic        use_base;
        logic [2:0]  base_rm;
        logic [15:0] disp;
        logic [5:0]  cyc;
        logic [1:0]  pen;
        jump_t       jump;
        logic [15:0] offset;
    } uop_t;

    typedef struct packed {
        logic        exec_en;
        logic        count_en;
        logic [15:0] prog_end;
    } cfg_t;

    typedef struct packed {
        logic [15:0] next_ip;
        logic [2:0]  instr_length;
        logic        sign_flag;
        logic        zero_flag;
        logic [5:0]  cycles_added;
        logic [31:0] cycle_total;
        logic        decode_error;
        logic        halted;
    } result_t;

    function automatic logic [15:0] sext8(input logic [7:0] v);
        return {{8{v[7]}}, v};
    endfunction

endpackage

/* hw/rtl/x86ex_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module x86ex_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end

endmodule

/* hw/rtl/x86ex_front.sv */
// Front end: classifies the instruction bytes into a micro-op and queues it.
// Depends on x86ex_pkg.
module x86ex_front (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             accept_en,
    input  logic             push,
    output logic             full,
    input  logic [7:0]       byte0,
    input  logic [7:0]       byte1,
    input  logic [7:0]       byte2,
    input  logic [7:0]       byte3,
    input  logic [7:0]       byte4,
    input  logic [7:0]       byte5,
    output x86ex_pkg::uop_t  head,
    output logic             head_valid,
    input  logic             head_pop
);
    import x86ex_pkg::*;

    localparam int unsigned PW = $clog2(QDEPTH);

    uop_t            u;
    uop_t            q_reg [QDEPTH];
    logic [PW-1:0]   wp_reg, rp_reg;
    logic [PW:0]     cnt_reg;
    logic            wr, rd;

    function automatic kind_t alu_of(input logic [2:0] k);
        kind_t r;
        case (k)
            ALU_ADD: r = K_ADD;
            ALU_SUB: r = K_SUB;
            ALU_CMP: r = K_CMP;
            default: r = K_NONE;
        endcase
        return r;
    endfunction

    always_comb
    begin
        logic [1:0]  md;
        logic [2:0]  rg, rmf;
        logic        is_reg, direct;
        logic [2:0]  rlen;
        logic [5:0]  ea;
        logic [15:0] rdisp;
        logic [7:0]  imm_lo, imm_hi;
        kind_t       kk;
        kk     = K_NONE;
        md     = byte1[7:6];
        rg     = byte1[5:3];
        rmf    = byte1[2:0];
        is_reg = (md == 2'd3);
        direct = (md == 2'd0) && (rmf == 3'd6);
        rlen   = is_reg ? 3'd2 : (direct ? 3'd4 : 3'd2 + {1'b0, md});
        if (direct)
            ea = 6'd6;
        else if (rmf < 3'd4)
            ea = ((rmf == 3'd0) || (rmf == 3'd3)) ? 6'd7 : 6'd8;
        else
            ea = 6'd5;
        if (!direct && (md != 2'd0))
            ea = ea + 6'd4;
        if (direct || (md == 2'd2))
            rdisp = {byte3, byte2};
        else if (md == 2'd1)
            rdisp = sext8(byte2);
        else
            rdisp = 16'd0;
        case (rlen)
            3'd2:    begin imm_lo = byte2; imm_hi = byte3; end
            3'd3:    begin imm_lo = byte3; imm_hi = byte4; end
            default: begin imm_lo = byte4; imm_hi = byte5; end
        endcase

        u          = '0;
        u.len      = 3'd1;
        u.kind     = K_NONE;
        u.src      = SRC_IMM;
        u.jump     = J_NONE;
        u.use_base = !direct;
        u.base_rm  = rmf;
        u.disp     = rdisp;
        u.offset   = sext8(byte1);

        if ((byte0[7:2] == OPC_MOV_RM) || ((byte0 < 8'h40) && !byte0[2]))
        begin
            kk    = (byte0[7:2] == OPC_MOV_RM) ? K_MOV : alu_of(byte0[5:3]);
            u.w   = byte0[0];
            u.len = rlen;
            if (kk == K_NONE)
            begin
                u.err = 1'b1;
            end
            else if (is_reg)
            begin
                u.kind = kk;
                u.src  = SRC_REG;
                u.dreg = byte0[1] ? rg : rmf;
                u.sreg = byte0[1] ? rmf : rg;
                u.cyc  = (kk == K_MOV) ? 6'd2 : ((kk == K_ADD) ? 6'd3 : 6'd0);
            end
            else if ((kk == K_MOV) || (kk == K_ADD))
            begin
                u.kind    = kk;
                u.dst_mem = !byte0[1];
                u.dreg    = rg;
                u.sreg    = rg;
                u.src     = byte0[1] ? SRC_MEM : SRC_REG;
                u.pen     = 2'd1;
                if (kk == K_MOV)
                    u.cyc = (byte0[1] ? 6'd8 : 6'd9) + ea;
                else if (byte0[1])
                    u.cyc = 6'd9 + ea;
                else
                begin
                    u.cyc = 6'd16 + ea;
                    u.pen = 2'd2;
                end
            end
        end
        else if (byte0[7:4] == OPC_MOV_IMR)
        begin
            u.w    = byte0[3];
            u.len  = 3'd2 + {2'b0, byte0[3]};
            u.imm  = {byte0[3] ? byte2 : 8'h00, byte1};
            u.kind = K_MOV;
            u.dreg = byte0[2:0];
            u.cyc  = 6'd4;
        end
        else if (byte0[7:1] == OPC_MOV_IRM)
        begin
            u.w    = byte0[0];
            u.len  = rlen + 3'd1 + {2'b0, byte0[0]};
            u.imm  = {byte0[0] ? imm_hi : 8'h00, imm_lo};
            u.kind = K_MOV;
            if (is_reg)
            begin
                u.dreg = rmf;
                u.cyc  = 6'd4;
            end
            else
            begin
                u.dst_mem = 1'b1;
                u.cyc     = 6'd10 + ea;
                u.pen     = 2'd1;
            end
        end
        else if (byte0 < 8'h40)
        begin
            kk  = alu_of(byte0[5:3]);
            u.w = byte0[0];
            if (byte0[1])
            begin
                u.err = 1'b1;
            end
            else
            begin
                u.len = 3'd2 + {2'b0, byte0[0]};
                u.imm = {byte0[0] ? byte2 : 8'h00, byte1};
                if (kk == K_NONE)
                    u.err = 1'b1;
                else
                begin
                    u.kind = kk;
                    u.cyc  = (kk == K_ADD) ? 6'd4 : 6'd0;
                end
            end
        end
        else if (byte0[7:2] == OPC_GRP_IMM)
        begin
            kk  = alu_of(rg);
            u.w = byte0[0];
            case (byte0[1:0])
                2'd1:    u.imm = {imm_hi, imm_lo};
                2'd3:    u.imm = sext8(imm_lo);
                default: u.imm = {8'h00, imm_lo};
            endcase
            u.len = rlen + ((byte0[1:0] == 2'd1) ? 3'd2 : 3'd1);
            if (kk == K_NONE)
                u.err = 1'b1;
            else if (is_reg)
            begin
                u.kind = kk;
                u.dreg = rmf;
                u.cyc  = (kk == K_ADD) ? 6'd4 : 6'd0;
            end
            else if (kk == K_ADD)
            begin
                u.kind    = K_ADD;
                u.dst_mem = 1'b1;
                u.cyc     = 6'd17 + ea;
                u.pen     = 2'd2;
            end
        end
        else if (byte0[7:4] == OPC_JCC)
        begin
            u.len = 3'd2;
            if (byte0[3:0] == CC_NE)
                u.jump = J_JNZ;
            else if (byte0[3:0] == CC_E)
                u.jump = J_JE;
        end
        else if ((byte0[7:4] == OPC_LOOP) && (byte0[3:0] < 4'd4))
        begin
            u.len = 3'd2;
            if (byte0[3:0] == LOOP_NZ)
                u.jump = J_LOOPNZ;
        end
        else
        begin
            u.err = 1'b1;
        end
    end

    assign full       = (cnt_reg == (PW+1)'(QDEPTH)) || !accept_en;
    assign wr         = push && !full;
    assign rd         = head_pop && head_valid;
    assign head_valid = (cnt_reg != '0);
    assign head       = q_reg[rp_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (wr)
                wp_reg <= wp_reg + 1'b1;
            if (rd)
                rp_reg <= rp_reg + 1'b1;
            if (wr && !rd)
                cnt_reg <= cnt_reg + 1'b1;
            else if (rd && !wr)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr)
            q_reg[wp_reg] <= u;
    end

endmodule

/* hw/rtl/x86ex_back.sv */
// Back end: register file, banked data memory, flags, pointer and cycle total;
// executes each micro-op in an address state and then an execute state, into a
// result queue. Depends on x86ex_pkg and x86ex_ram.
module x86ex_back #(
    parameter int unsigned MEM_BYTES = x86ex_pkg::MEM_BYTES_DEF,
    parameter int unsigned NUM_REGS  = x86ex_pkg::NUM_REGS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  x86ex_pkg::cfg_t     cfg,
    input  x86ex_pkg::uop_t     uop,
    input  logic                uop_valid,
    output logic                uop_pop,
    output logic                clearing,
    output x86ex_pkg::result_t  res,
    output logic                empty,
    input  logic                pop
);
    import x86ex_pkg::*;

    localparam int unsigned AW         = $clog2(MEM_BYTES);
    localparam int unsigned BANK_DEPTH = MEM_BYTES / 2;
    localparam int unsigned BW         = AW - 1;
    localparam int unsigned PW         = $clog2(QDEPTH);

    state_t         state_reg, state_next;
    logic [BW-1:0]  clr_reg, clr_next;
    logic [15:0]    regs_reg [NUM_REGS];
    logic [15:0]    regs_next [NUM_REGS];
    logic           sf_reg, sf_next, zf_reg, zf_next;
    logic [15:0]    ip_reg, ip_next;
    logic [31:0]    tot_reg, tot_next;
    logic [15:0]    addr_reg, addr_next;

    result_t        rq_reg [QDEPTH];
    logic [PW-1:0]  rwp_reg, rrp_reg;
    logic [PW:0]    rq_count_reg;
    logic           rq_push, rq_pop, room;
    result_t        rnew;

    logic           go, halt_now, do_exec, do_clear, latch_addr;
    logic [15:0]    base, calc_addr;
    logic [AW-1:0]  ca_lo, ca_hi, wa_lo, wa_hi;
    logic [BW-1:0]  ev_raddr, od_raddr, ev_waddr, od_waddr, ev_wa, od_wa;
    logic [7:0]     ev_q, od_q, ev_wd, od_wd, m_lo, m_hi;
    logic           ev_we, od_we, mem_wr;
    logic [15:0]    memval, va, vb, sum, rslt, wval, cx_dec;
    logic           taken, set_flags;
    logic [5:0]     cyc;

    function automatic logic [15:0] rd_reg(input logic [15:0] g [NUM_REGS],
                                           input logic w, input logic [2:0] i);
        logic [15:0] r;
        if (w)
            r = g[i];
        else if (i[2])
            r = {8'h00, g[i[1:0]][15:8]};
        else
            r = {8'h00, g[i[1:0]][7:0]};
        return r;
    endfunction

    assign room     = (rq_count_reg != (PW+1)'(QDEPTH));
    assign go       = uop_valid && room;
    assign halt_now = (ip_reg >= cfg.prog_end);
    assign clearing = (state_reg == S_CLEAR);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:
            begin
                if (clr_reg == BW'(BANK_DEPTH - 1))
                    state_next = S_ADDR;
            end
            S_ADDR:
            begin
                if (go && !halt_now)
                    state_next = S_EXEC;
            end
            S_EXEC:  state_next = S_ADDR;
            default: state_next = S_ADDR;
        endcase
    end

    // control outputs
    always_comb
    begin
        uop_pop    = 1'b0;
        do_exec    = 1'b0;
        do_clear   = 1'b0;
        latch_addr = 1'b0;
        case (state_reg)
            S_CLEAR: do_clear = 1'b1;
            S_ADDR:
            begin
                uop_pop    = go && halt_now;
                latch_addr = go && !halt_now;
            end
            S_EXEC:
            begin
                uop_pop = 1'b1;
                do_exec = 1'b1;
            end
            default: ;
        endcase
    end

    always_comb
    begin
        case (uop.base_rm)
            3'd0:    base = regs_reg[3] + regs_reg[6];
            3'd1:    base = regs_reg[3] + regs_reg[7];
            3'd2:    base = regs_reg[5] + regs_reg[6];
            3'd3:    base = regs_reg[5] + regs_reg[7];
            3'd4:    base = regs_reg[6];
            3'd5:    base = regs_reg[7];
            3'd6:    base = regs_reg[5];
            default: base = regs_reg[3];
        endcase
        calc_addr = (uop.use_base ? base : 16'd0) + uop.disp;
        ca_lo     = AW'(calc_addr);
        ca_hi     = AW'(16'(calc_addr + 16'd1));
        ev_raddr  = calc_addr[0] ? ca_hi[AW-1:1] : ca_lo[AW-1:1];
        od_raddr  = ca_lo[AW-1:1];
        wa_lo     = AW'(addr_reg);
        wa_hi     = AW'(16'(addr_reg + 16'd1));
        ev_wa     = addr_reg[0] ? wa_hi[AW-1:1] : wa_lo[AW-1:1];
        od_wa     = wa_lo[AW-1:1];
        addr_next = latch_addr ? calc_addr : addr_reg;
    end

    // execute
    always_comb
    begin
        m_lo   = addr_reg[0] ? od_q : ev_q;
        m_hi   = addr_reg[0] ? ev_q : od_q;
        memval = uop.w ? {m_hi, m_lo} : {8'h00, m_lo};
        va     = uop.dst_mem ? memval : rd_reg(regs_reg, uop.w, uop.dreg);
        case (uop.src)
            SRC_REG: vb = rd_reg(regs_reg, uop.w, uop.sreg);
            SRC_MEM: vb = memval;
            default: vb = uop.imm;
        endcase
        sum       = (uop.kind == K_ADD) ? (va + vb) : (va - vb);
        rslt      = uop.w ? sum : {8'h00, sum[7:0]};
        wval      = (uop.kind == K_MOV) ? vb : rslt;
        set_flags = do_exec && cfg.exec_en &&
                    ((uop.kind == K_ADD) || (uop.kind == K_SUB) || (uop.kind == K_CMP));
        mem_wr    = do_exec && cfg.exec_en && uop.dst_mem &&
                    ((uop.kind == K_MOV) || (uop.kind == K_ADD));

        sf_next = sf_reg;
        zf_next = zf_reg;
        if (set_flags)
        begin
            sf_next = uop.w ? rslt[15] : rslt[7];
            zf_next = (rslt == 16'd0);
        end

        regs_next = regs_reg;
        cx_dec    = regs_reg[1] - 16'd1;
        taken     = 1'b0;
        if (do_exec && cfg.exec_en)
        begin
            if (!uop.dst_mem && ((uop.kind == K_MOV) || (uop.kind == K_ADD) ||
                                 (uop.kind == K_SUB)))
            begin
                if (uop.w)
                    regs_next[uop.dreg] = wval;
                else if (uop.dreg[2])
                    regs_next[uop.dreg[1:0]][15:8] = wval[7:0];
                else
                    regs_next[uop.dreg[1:0]][7:0] = wval[7:0];
            end
            case (uop.jump)
                J_JE:  taken = zf_reg;
                J_JNZ: taken = !zf_reg;
                J_LOOPNZ:
                begin
                    regs_next[1] = cx_dec;
                    taken        = (cx_dec != 16'd0) && !zf_reg;
                end
                default: taken = 1'b0;
            endcase
        end

        ip_next = ip_reg;
        if (do_exec)
            ip_next = ip_reg + {13'd0, uop.len} + (taken ? uop.offset : 16'd0);

        if (uop.err || !cfg.count_en)
            cyc = 6'd0;
        else
            cyc = uop.cyc + ((uop.w && addr_reg[0]) ? {2'b00, uop.pen, 2'b00} : 6'd0);
        tot_next = do_exec ? (tot_reg + {26'd0, cyc}) : tot_reg;

        rnew.next_ip      = ip_next;
        rnew.instr_length = uop.len;
        rnew.sign_flag    = sf_next;
        rnew.zero_flag    = zf_next;
        rnew.cycles_added = cyc;
        rnew.cycle_total  = tot_next;
        rnew.decode_error = uop.err;
        rnew.halted       = (ip_next >= cfg.prog_end);
        rq_push           = do_exec;
    end

    // memory bank ports
    always_comb
    begin
        clr_next = do_clear ? clr_reg + 1'b1 : clr_reg;
        if (do_clear)
        begin
            ev_we    = 1'b1;
            od_we    = 1'b1;
            ev_waddr = clr_reg;
            od_waddr = clr_reg;
            ev_wd    = 8'h00;
            od_wd    = 8'h00;
        end
        else
        begin
            ev_we    = mem_wr && (uop.w || !addr_reg[0]);
            od_we    = mem_wr && (uop.w || addr_reg[0]);
            ev_waddr = ev_wa;
            od_waddr = od_wa;
            ev_wd    = addr_reg[0] ? wval[15:8] : wval[7:0];
            od_wd    = addr_reg[0] ? wval[7:0] : wval[15:8];
        end
    end

    x86ex_ram #(.WIDTH(8), .DEPTH(BANK_DEPTH)) u_even (
        .clk   (clk),
        .we    (ev_we),
        .waddr (ev_waddr),
        .wdata (ev_wd),
        .raddr (ev_raddr),
        .rdata (ev_q)
    );

    x86ex_ram #(.WIDTH(8), .DEPTH(BANK_DEPTH)) u_odd (
        .clk   (clk),
        .we    (od_we),
        .waddr (od_waddr),
        .wdata (od_wd),
        .raddr (od_raddr),
        .rdata (od_q)
    );

    assign rq_pop = pop && !empty;
    assign empty  = (rq_count_reg == '0);
    assign res    = rq_reg[rrp_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_CLEAR;
            clr_reg      <= '0;
            for (int i = 0; i < NUM_REGS; i++)
                regs_reg[i] <= '0;
            sf_reg       <= 1'b0;
            zf_reg       <= 1'b0;
            ip_reg       <= '0;
            tot_reg      <= '0;
            rwp_reg      <= '0;
            rrp_reg      <= '0;
            rq_count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            regs_reg  <= regs_next;
            sf_reg    <= sf_next;
            zf_reg    <= zf_next;
            ip_reg    <= ip_next;
            tot_reg   <= tot_next;
            if (rq_push)
                rwp_reg <= rwp_reg + 1'b1;
            if (rq_pop)
                rrp_reg <= rrp_reg + 1'b1;
            if (rq_push && !rq_pop)
                rq_count_reg <= rq_count_reg + 1'b1;
            else if (rq_pop && !rq_push)
                rq_count_reg <= rq_count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg <= addr_next;
        if (rq_push)
            rq_reg[rwp_reg] <= rnew;
    end

    a_exec_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_EXEC |=> state_reg == S_ADDR)
        else $error("execute phase lasted more than one cycle");

    a_no_work_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_CLEAR |-> !uop_pop && !rq_push)
        else $error("micro-op consumed during memory clear");

    a_result_room: assert property (@(posedge clk) disable iff (!rst_n)
        rq_push |-> rq_count_reg < (PW+1)'(QDEPTH))
        else $error("result queue overflow");

    a_pop_needs_op: assert property (@(posedge clk) disable iff (!rst_n)
        uop_pop |-> uop_valid)
        else $error("micro-op queue underflow");

endmodule

/* hw/rtl/x86_16_subset_instruction_executor.sv */
// Top level of the x86 subset executor: APB register file, front end, back end.
// Depends on x86ex_pkg, x86ex_front, x86ex_back.
//
//   channel   handshake         payload
//   input     push / full       byte0 .. byte5
//   result    empty / pop       next_ip, instr_length, sign_flag, zero_flag,
//                               cycles_added, cycle_total, decode_error, halted
//   config    psel/penable/...  execute_enable, count_clocks, program_end
//
// Each instruction passes through an address state (register read, effective
// address, data-memory read) and an execute state (ALU, write-back, flags).
// An instruction met with the pointer at or past program_end is dropped with
// no result. Two-deep queues sit between front, back and result port. After
// reset, full stays high while both byte banks clear.
module x86_16_subset_instruction_executor #(
    parameter int unsigned MEM_BYTES = x86ex_pkg::MEM_BYTES_DEF,
    parameter int unsigned NUM_REGS  = x86ex_pkg::NUM_REGS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  byte0,
    input  logic [7:0]  byte1,
    input  logic [7:0]  byte2,
    input  logic [7:0]  byte3,
    input  logic [7:0]  byte4,
    input  logic [7:0]  byte5,
    output logic        empty,
    input  logic        pop,
    output logic [15:0] next_ip,
    output logic [2:0]  instr_length,
    output logic        sign_flag,
    output logic        zero_flag,
    output logic [5:0]  cycles_added,
    output logic [31:0] cycle_total,
    output logic        decode_error,
    output logic        halted
);
    import x86ex_pkg::*;

    cfg_t     cfg_reg;
    uop_t     head;
    logic     head_valid, head_pop, clearing;
    result_t  res;
    logic     cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.exec_en  <= 1'b1;
            cfg_reg.count_en <= 1'b1;
            cfg_reg.prog_end <= 16'hFFFF;
        end
        else if (cfg_wr)
        begin
            case (paddr[3:2])
                CFG_EXEC:   cfg_reg.exec_en  <= pwdata[0];
                CFG_CLOCKS: cfg_reg.count_en <= pwdata[0];
                CFG_END:    cfg_reg.prog_end <= pwdata[15:0];
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            CFG_EXEC:   prdata = {31'd0, cfg_reg.exec_en};
            CFG_CLOCKS: prdata = {31'd0, cfg_reg.count_en};
            CFG_END:    prdata = {16'd0, cfg_reg.prog_end};
            default:    prdata = 32'd0;
        endcase
    end

    x86ex_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept_en  (!clearing),
        .push       (push),
        .full       (full),
        .byte0      (byte0),
        .byte1      (byte1),
        .byte2      (byte2),
        .byte3      (byte3),
        .byte4      (byte4),
        .byte5      (byte5),
        .head       (head),
        .head_valid (head_valid),
        .head_pop   (head_pop)
    );

    x86ex_back #(.MEM_BYTES(MEM_BYTES), .NUM_REGS(NUM_REGS)) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .uop       (head),
        .uop_valid (head_valid),
        .uop_pop   (head_pop),
        .clearing  (clearing),
        .res       (res),
        .empty     (empty),
        .pop       (pop)
    );

    assign next_ip      = res.next_ip;
    assign instr_length = res.instr_length;
    assign sign_flag    = res.sign_flag;
    assign zero_flag    = res.zero_flag;
    assign cycles_added = res.cycles_added;
    assign cycle_total  = res.cycle_total;
    assign decode_error = res.decode_error;
    assign halted       = res.halted;

endmodule
